[rtl/bpp_pkg.sv]
// Types, stage numbering and arithmetic helpers for the Boris particle push pipeline.
// Has no dependencies; the pipeline top level uses everything here.
package bpp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_EHALF = 2'd0;
    localparam logic [1:0] CFG_MHALF = 2'd1;
    localparam logic [1:0] CFG_DT    = 2'd2;

    localparam logic [31:0] EHALF_RST = 32'd279620267;
    localparam logic [31:0] MHALF_RST = 32'd83886;
    localparam logic [30:0] DT_RST    = 31'd167772;

    // The quotient s is at most about 2^24, so 26 quotient bits suffice
    localparam int DIV_BITS = 26;

    // Stage numbering
    localparam int ST_PROD  = 0;
    localparam int ST_KICK  = 1;
    localparam int ST_CROSS = 2;
    localparam int ST_VP    = 3;
    localparam int ST_NUM   = 4;
    localparam int ST_DIV0  = 5;
    localparam int ST_SIGN  = ST_DIV0 + DIV_BITS;
    localparam int ST_SPROD = ST_SIGN + 1;
    localparam int ST_VNEW  = ST_SPROD + 1;
    localparam int ST_DRIFT = ST_VNEW + 1;
    localparam int ST_POS   = ST_DRIFT + 1;
    localparam int NS       = ST_POS + 1;

    localparam logic signed [47:0] MAX48 = 48'sd2147483647;
    localparam logic signed [47:0] MIN48 = -48'sd2147483648;

    typedef struct packed {
        logic [2:0][31:0] x;
        logic [2:0][31:0] v;
        logic [2:0][39:0] k;
        logic [2:0][31:0] vm;
        logic [2:0][31:0] t;
        logic [2:0][31:0] vp;
        logic [2:0][31:0] nv;
        logic [2:0][63:0] pa;
        logic [2:0][63:0] pb;
        logic [2:0][63:0] sq;
        logic [2:0][26:0] s;
        logic [2:0][40:0] rem;
        logic [2:0][25:0] nlo;
        logic [2:0][25:0] quo;
        logic [2:0]       tneg;
        logic [40:0]      d;
        logic             ov;
    } t_item;

    function automatic int nxt(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic int prv(input int i);
        return (i == 0) ? 2 : i - 1;
    endfunction

    // Round to nearest, ties up, then shift right by n
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p, input int n);
        return (p + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        if (v > MAX48) begin
            return 32'h7FFF_FFFF;
        end else if (v < MIN48) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [47:0] v);
        return (v > MAX48) || (v < MIN48);
    endfunction

endpackage

[rtl/boris_particle_push.sv]
// Boris particle push: one non-relativistic step per particle, Q16.16 in and out.
// Throughput is one particle per cycle while the output side is not stalled; the 26-stage
// restoring divider for s = 2t/(1+|t|^2) sets the pipeline depth.
// Each stage holds when its successor is full and stalled, so bubbles close up.
// Synchronous active-low reset clears valid bits and restores the gain registers.
// Depends on bpp_pkg.
module boris_particle_push (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_efield_x,
    input  logic signed [31:0] i_efield_y,
    input  logic signed [31:0] i_efield_z,
    input  logic signed [31:0] i_bfield_x,
    input  logic signed [31:0] i_bfield_y,
    input  logic signed [31:0] i_bfield_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic               o_overflow
);

    logic [31:0] r_ke;
    logic [31:0] r_km;
    logic [30:0] r_dt;

    bpp_pkg::t_item       r_st   [bpp_pkg::NS];
    bpp_pkg::t_item       n_st   [bpp_pkg::NS];
    bpp_pkg::t_item       w_prev [bpp_pkg::NS];
    logic [bpp_pkg::NS-1:0] r_vld;
    logic [bpp_pkg::NS:0]   w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ke <= bpp_pkg::EHALF_RST;
            r_km <= bpp_pkg::MHALF_RST;
            r_dt <= bpp_pkg::DT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpp_pkg::CFG_EHALF: r_ke <= i_cfg_data;
                bpp_pkg::CFG_MHALF: r_km <= i_cfg_data;
                bpp_pkg::CFG_DT:    r_dt <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Stage advances when empty or when its successor advances
    assign w_go[bpp_pkg::NS] = i_out_ready;
    assign o_in_ready        = w_go[0];

    always_comb begin
        w_prev[0]    = '0;
        w_prev[0].x  = {i_pos_z, i_pos_y, i_pos_x};
        w_prev[0].v  = {i_vel_z, i_vel_y, i_vel_x};
        w_prev[0].pa = {64'(i_efield_z), 64'(i_efield_y), 64'(i_efield_x)};
        w_prev[0].pb = {64'(i_bfield_z), 64'(i_bfield_y), 64'(i_bfield_x)};
    end

    for (genvar gi = 0; gi < bpp_pkg::NS; gi++) begin : g_st
        if (gi > 0) begin : g_link
            assign w_prev[gi] = r_st[gi-1];
        end

        assign w_go[gi] = !r_vld[gi] || w_go[gi+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (w_go[gi]) begin
                r_vld[gi] <= (gi == 0) ? i_in_valid : r_vld[(gi == 0) ? 0 : gi - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_go[gi]) begin
                r_st[gi] <= n_st[gi];
            end
        end

        if (gi == bpp_pkg::ST_PROD) begin : g_prod
            // pa/pb carry the raw E and B fields into this stage
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].pa[i] = 64'($signed(w_prev[gi].pa[i][31:0])) * 64'($signed(r_ke));
                    n_st[gi].pb[i] = 64'($signed(w_prev[gi].pb[i][31:0])) * 64'($signed(r_km));
                end
            end
        end else if (gi == bpp_pkg::ST_KICK) begin : g_kick
            logic signed [47:0] n_vsum [3];
            logic signed [47:0] n_tw   [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].k[i] = 40'(bpp_pkg::rnd_shr($signed(w_prev[gi].pa[i]), 24));
                    n_vsum[i] = 48'($signed(w_prev[gi].v[i])) + 48'($signed(n_st[gi].k[i]));
                    n_tw[i]   = 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pb[i]), 16));
                    n_st[gi].vm[i] = bpp_pkg::sat32(n_vsum[i]);
                    n_st[gi].t[i]  = bpp_pkg::sat32(n_tw[i]);
                    if (bpp_pkg::ovf32(n_vsum[i]) || bpp_pkg::ovf32(n_tw[i])) begin
                        n_st[gi].ov = 1'b1;
                    end
                end
            end
        end else if (gi == bpp_pkg::ST_CROSS) begin : g_cross
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].pa[i] = 64'($signed(w_prev[gi].vm[bpp_pkg::nxt(i)]))
                                   * 64'($signed(w_prev[gi].t[bpp_pkg::prv(i)]));
                    n_st[gi].pb[i] = 64'($signed(w_prev[gi].vm[bpp_pkg::prv(i)]))
                                   * 64'($signed(w_prev[gi].t[bpp_pkg::nxt(i)]));
                    n_st[gi].sq[i] = 64'($signed(w_prev[gi].t[i]))
                                   * 64'($signed(w_prev[gi].t[i]));
                end
            end
        end else if (gi == bpp_pkg::ST_VP) begin : g_vp
            logic [64:0]        n_tsum;
            logic signed [47:0] n_psum [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                n_tsum = 65'(w_prev[gi].sq[0]) + 65'(w_prev[gi].sq[1])
                       + 65'(w_prev[gi].sq[2]) + 65'(64'd1 << 23);
                n_st[gi].d = 41'(n_tsum >> 24) + 41'(64'd1 << 24);
                for (int i = 0; i < 3; i++) begin
                    n_psum[i] = 48'($signed(w_prev[gi].vm[i]))
                              + 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pa[i]), 24))
                              - 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pb[i]), 24));
                    n_st[gi].vp[i] = bpp_pkg::sat32(n_psum[i]);
                    if (bpp_pkg::ovf32(n_psum[i])) begin
                        n_st[gi].ov = 1'b1;
                    end
                    // keep the magnitude of t from here on
                    n_st[gi].tneg[i] = w_prev[gi].t[i][31];
                    n_st[gi].t[i] = w_prev[gi].t[i][31] ? 32'(-w_prev[gi].t[i])
                                                        : w_prev[gi].t[i];
                end
            end
        end else if (gi == bpp_pkg::ST_NUM) begin : g_num
            logic [57:0] n_num [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_num[i] = 58'({w_prev[gi].t[i], 25'd0}) + 58'(w_prev[gi].d >> 1);
                    n_st[gi].rem[i] = 41'(n_num[i][57:26]);
                    n_st[gi].nlo[i] = n_num[i][25:0];
                    n_st[gi].quo[i] = '0;
                end
            end
        end else if (gi < bpp_pkg::ST_SIGN) begin : g_div
            // one restoring-division bit per stage
            logic [41:0] n_trial [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_trial[i] = {w_prev[gi].rem[i], w_prev[gi].nlo[i][25]};
                    n_st[gi].nlo[i] = {w_prev[gi].nlo[i][24:0], 1'b0};
                    if (n_trial[i] >= {1'b0, w_prev[gi].d}) begin
                        n_st[gi].rem[i] = 41'(n_trial[i] - {1'b0, w_prev[gi].d});
                        n_st[gi].quo[i] = {w_prev[gi].quo[i][24:0], 1'b1};
                    end else begin
                        n_st[gi].rem[i] = n_trial[i][40:0];
                        n_st[gi].quo[i] = {w_prev[gi].quo[i][24:0], 1'b0};
                    end
                end
            end
        end else if (gi == bpp_pkg::ST_SIGN) begin : g_sign
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].s[i] = w_prev[gi].tneg[i] ? 27'(-{1'b0, w_prev[gi].quo[i]})
                                                       : {1'b0, w_prev[gi].quo[i]};
                end
            end
        end else if (gi == bpp_pkg::ST_SPROD) begin : g_sprod
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].pa[i] = 64'($signed(w_prev[gi].vp[bpp_pkg::nxt(i)]))
                                   * 64'($signed(w_prev[gi].s[bpp_pkg::prv(i)]));
                    n_st[gi].pb[i] = 64'($signed(w_prev[gi].vp[bpp_pkg::prv(i)]))
                                   * 64'($signed(w_prev[gi].s[bpp_pkg::nxt(i)]));
                end
            end
        end else if (gi == bpp_pkg::ST_VNEW) begin : g_vnew
            logic signed [47:0] n_vsum [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_vsum[i] = 48'($signed(w_prev[gi].vm[i]))
                              + 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pa[i]), 24))
                              - 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pb[i]), 24))
                              + 48'($signed(w_prev[gi].k[i]));
                    n_st[gi].nv[i] = bpp_pkg::sat32(n_vsum[i]);
                    if (bpp_pkg::ovf32(n_vsum[i])) begin
                        n_st[gi].ov = 1'b1;
                    end
                end
            end
        end else if (gi == bpp_pkg::ST_DRIFT) begin : g_drift
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_st[gi].pa[i] = 64'($signed(w_prev[gi].nv[i]))
                                   * $signed(64'({1'b0, r_dt}));
                end
            end
        end else begin : g_pos
            logic signed [47:0] n_xsum [3];
            always_comb begin
                n_st[gi] = w_prev[gi];
                for (int i = 0; i < 3; i++) begin
                    n_xsum[i] = 48'($signed(w_prev[gi].x[i]))
                              + 48'(bpp_pkg::rnd_shr($signed(w_prev[gi].pa[i]), 24));
                    n_st[gi].x[i] = bpp_pkg::sat32(n_xsum[i]);
                    if (bpp_pkg::ovf32(n_xsum[i])) begin
                        n_st[gi].ov = 1'b1;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_vld[bpp_pkg::NS-1];
    assign o_new_pos_x = $signed(r_st[bpp_pkg::NS-1].x[0]);
    assign o_new_pos_y = $signed(r_st[bpp_pkg::NS-1].x[1]);
    assign o_new_pos_z = $signed(r_st[bpp_pkg::NS-1].x[2]);
    assign o_new_vel_x = $signed(r_st[bpp_pkg::NS-1].nv[0]);
    assign o_new_vel_y = $signed(r_st[bpp_pkg::NS-1].nv[1]);
    assign o_new_vel_z = $signed(r_st[bpp_pkg::NS-1].nv[2]);
    assign o_overflow  = r_st[bpp_pkg::NS-1].ov;

endmodule
